/* rtl/cic_pkg.sv */
// Shared types and constants for the cassette interface card.
// Used by the controller, the datapath and the top level.
package cic_pkg;

  localparam int TapeDepthDef = 16384;

  localparam logic [2:0] FUNC_READ  = 3'd0;
  localparam logic [2:0] FUNC_WRITE = 3'd1;
  localparam logic [2:0] FUNC_TICK  = 3'd2;
  localparam logic [2:0] FUNC_ROM   = 3'd3;
  localparam logic [2:0] FUNC_TAPE  = 3'd4;
  localparam logic [2:0] FUNC_START = 3'd5;

  localparam logic [15:0] ROM_LOW  = 16'hC100;
  localparam logic [15:0] ROM_HIGH = 16'hC1FF;
  localparam logic [15:0] IN_REG   = 16'hC081;
  localparam logic [15:0] IO_LOW   = 16'hC000;
  localparam logic [15:0] IO_HIGH  = 16'hC0FF;
  localparam logic [7:0]  LEVEL_BIT = 8'h80;
  localparam logic [31:0] REWIND_GAP_RST = 32'd511500;

  localparam logic [1:0] REG_LENGTH = 2'd0;
  localparam logic [1:0] REG_LEVEL  = 2'd1;
  localparam logic [1:0] REG_GAP    = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch the input word and start its work
    logic exec;      // apply the captured word (read result read back)
    logic rd_next;   // issue a tape memory read: entry zero, or the entry after the play position for a tick
    logic replay;    // consume one duration read from tape memory
    logic done;      // emit the result word
  } cic_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic tick_loop;   // tick must keep replaying durations
  } cic_stat_t;

endpackage

/* rtl/cic_ctrl.sv */
// Sequencer for the cassette interface card.
// Depends on cic_pkg for the command and status structs.
module cic_ctrl
  import cic_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  cic_stat_t stat,
  output cic_cmd_t  cmd
);

  typedef enum logic [2:0] {S_IDLE, S_FETCH, S_EXEC, S_LOOP, S_WAIT, S_DONE} state_t;

  state_t state_r, state_nxt;

  // pick next state
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.rd_next = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = S_LOOP;
      end
      S_LOOP: begin
        if (stat.tick_loop) begin
          cmd.rd_next = 1'b1;
          state_nxt = S_WAIT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WAIT: begin
        cmd.replay = 1'b1;
        state_nxt = S_LOOP;
      end
      S_DONE: begin
        cmd.done = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

/* rtl/cic_dp.sv */
// Datapath of the cassette interface card: ROM, tape memory, counters, levels.
// Depends on cic_pkg; driven by cic_ctrl commands.
module cic_dp
  import cic_pkg::*;
#(
  parameter int TAPE_DEPTH = TapeDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cic_cmd_t    cmd,
  output cic_stat_t   stat,
  input  logic [2:0]  in_func,
  input  logic [15:0] in_addr,
  input  logic [7:0]  in_data_byte,
  input  logic [7:0]  in_tick_cycles,
  input  logic [13:0] in_tape_index,
  input  logic [30:0] in_tape_duration,
  input  logic [14:0] tape_length,
  input  logic        tape_start_level,
  input  logic [31:0] rewind_gap,
  output logic        out_strobe,
  output logic [7:0]  out_read_data,
  output logic        out_recorded_valid,
  output logic [31:0] out_recorded_delta,
  output logic        out_first_toggle,
  output logic        out_tape_out,
  output logic        out_tape_in,
  output logic        out_tape_running
);

  localparam int AW = $clog2(TAPE_DEPTH);
  localparam int PW = AW + 1;

  logic [7:0]  rom_mem [256];
  logic [30:0] tape_mem [TAPE_DEPTH];

  logic [2:0]  func_r;
  logic [15:0] addr_r;
  logic [7:0]  cyc_r;
  logic [7:0]  rom_q_r;
  logic [30:0] tape_q_r;
  logic [PW-1:0] rd_addr;

  logic [31:0] cycle_count_r, last_toggle_r, last_read_r;
  logic signed [33:0] countdown_r;
  logic [PW-1:0] pos_r;
  logic in_level_r, out_level_r, begun_r, playing_r, ready_r;
  logic rec_valid_r, rec_first_r;
  logic [31:0] rec_delta_r;
  logic [7:0] rd_r;

  logic [PW-1:0] eff_len;
  logic [PW-1:0] pos_inc;
  logic [31:0] gap;
  logic is_io, is_rom, do_toggle, rewind;

  // clamp tape length to depth
  always_comb begin
    if (32'(tape_length) > 32'(TAPE_DEPTH)) begin
      eff_len = PW'(TAPE_DEPTH);
    end else begin
      eff_len = PW'(tape_length);
    end
  end

  assign pos_inc = pos_r + 1'b1;
  assign gap = cycle_count_r - last_read_r;
  assign is_io = (addr_r >= IO_LOW) && (addr_r <= IO_HIGH);
  assign is_rom = (addr_r >= ROM_LOW) && (addr_r <= ROM_HIGH);
  assign rewind = ready_r && (pos_r != '0) && (gap > rewind_gap);
  assign do_toggle = ((func_r == FUNC_READ) && is_io) ||
                     ((func_r == FUNC_WRITE) && is_io && (addr_r != IN_REG));

  // only a tick replays durations
  assign stat.tick_loop = (func_r == FUNC_TICK) && ready_r && playing_r &&
                          (countdown_r <= 0);

  // memory read address: entry after the play position for a tick, else entry zero
  assign rd_addr = (func_r == FUNC_TICK) ? pos_inc : '0;

  // memories
  always_ff @(posedge clk) begin
    if (cmd.capture && in_func == FUNC_ROM) begin
      rom_mem[in_addr[7:0]] <= in_data_byte;
    end
    if (cmd.capture && in_func == FUNC_TAPE && 32'(in_tape_index) < 32'(TAPE_DEPTH)) begin
      tape_mem[AW'(in_tape_index)] <= in_tape_duration;
    end
    rom_q_r <= rom_mem[addr_r[7:0]];
    if (cmd.rd_next) begin
      tape_q_r <= (rd_addr < PW'(TAPE_DEPTH)) ? tape_mem[rd_addr[AW-1:0]] : '0;
    end
  end

  // capture input word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      addr_r <= in_addr;
      cyc_r  <= in_tick_cycles;
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_count_r <= '0;
      last_toggle_r <= '0;
      last_read_r <= '0;
      countdown_r <= '0;
      pos_r <= '0;
      in_level_r <= 1'b0;
      out_level_r <= 1'b0;
      begun_r <= 1'b0;
      playing_r <= 1'b0;
      ready_r <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= cmd.done;
      if (cmd.capture) begin
        rec_valid_r <= 1'b0;
        rec_first_r <= 1'b0;
        rec_delta_r <= '0;
        rd_r <= '0;
      end
      if (cmd.exec) begin
        case (func_r)
          FUNC_READ: begin
            if (is_rom) begin
              rd_r <= rom_q_r;
            end else if (addr_r == IN_REG) begin
              last_read_r <= cycle_count_r;
              if (rewind) begin
                pos_r <= '0;
                countdown_r <= 34'(tape_q_r);
                in_level_r <= tape_start_level;
                playing_r <= 1'b1;
                rd_r <= tape_start_level ? LEVEL_BIT : 8'h00;
              end else begin
                rd_r <= in_level_r ? LEVEL_BIT : 8'h00;
              end
            end
          end
          FUNC_TICK: begin
            cycle_count_r <= cycle_count_r + 32'(cyc_r);
            if (ready_r && playing_r) begin
              countdown_r <= countdown_r - 34'(cyc_r);
            end
          end
          FUNC_START: begin
            pos_r <= '0;
            cycle_count_r <= '0;
            last_read_r <= '0;
            countdown_r <= 34'(tape_q_r);
            in_level_r <= tape_start_level;
            ready_r <= 1'b1;
            playing_r <= 1'b1;
          end
          default: ;
        endcase
        if (do_toggle) begin
          out_level_r <= ~out_level_r;
          last_toggle_r <= cycle_count_r;
          if (!begun_r) begin
            begun_r <= 1'b1;
            rec_first_r <= 1'b1;
          end else if (cycle_count_r != last_toggle_r) begin
            rec_valid_r <= 1'b1;
            rec_delta_r <= cycle_count_r - last_toggle_r;
          end
        end
      end
      // replay one duration: flip, advance, stop or reload
      if (cmd.replay) begin
        in_level_r <= ~in_level_r;
        pos_r <= pos_inc;
        if (pos_inc >= eff_len) begin
          playing_r <= 1'b0;
        end else begin
          countdown_r <= countdown_r + 34'(tape_q_r);
        end
      end
    end
  end

  assign out_read_data = rd_r;
  assign out_recorded_valid = rec_valid_r;
  assign out_recorded_delta = rec_delta_r;
  assign out_first_toggle = rec_first_r;
  assign out_tape_out = out_level_r;
  assign out_tape_in = in_level_r;
  assign out_tape_running = playing_r;

endmodule

/* rtl/cassette_interface_card.sv */
// Cassette interface card top level: APB registers, controller, datapath.
// Each word passes the capture, fetch, execute, loop and result steps of the
// controller, and a tick adds a wait step per duration replayed; out_strobe is
// registered from the result step. A new word is taken only once the controller is idle.
// Reset: synchronous active-low rst_n clears control and levels; memories keep contents.
// The receiver cannot stall; each result shows for one cycle with out_strobe.
module cassette_interface_card
  import cic_pkg::*;
#(
  parameter int TAPE_DEPTH = TapeDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [15:0] in_addr,
  input  logic [7:0]  in_data_byte,
  input  logic [7:0]  in_tick_cycles,
  input  logic [13:0] in_tape_index,
  input  logic [30:0] in_tape_duration,
  output logic        out_strobe,
  output logic [7:0]  out_read_data,
  output logic        out_recorded_valid,
  output logic [31:0] out_recorded_delta,
  output logic        out_first_toggle,
  output logic        out_tape_out,
  output logic        out_tape_in,
  output logic        out_tape_running,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [14:0] cfg_length_r;
  logic        cfg_level_r;
  logic [31:0] cfg_gap_r;
  logic        wr_en;
  cic_cmd_t    cmd;
  cic_stat_t   stat;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_length_r <= 15'd1;
      cfg_level_r <= 1'b0;
      cfg_gap_r <= REWIND_GAP_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_LENGTH: cfg_length_r <= pwdata[14:0];
        REG_LEVEL:  cfg_level_r <= pwdata[0];
        REG_GAP:    cfg_gap_r <= pwdata;
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[3:2])
      REG_LENGTH: prdata = {17'd0, cfg_length_r};
      REG_LEVEL:  prdata = {31'd0, cfg_level_r};
      REG_GAP:    prdata = cfg_gap_r;
      default:    prdata = '0;
    endcase
  end

  cic_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .stat(stat), .cmd(cmd)
  );

  cic_dp #(.TAPE_DEPTH(TAPE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_func(in_func), .in_addr(in_addr), .in_data_byte(in_data_byte),
    .in_tick_cycles(in_tick_cycles), .in_tape_index(in_tape_index),
    .in_tape_duration(in_tape_duration),
    .tape_length(cfg_length_r), .tape_start_level(cfg_level_r), .rewind_gap(cfg_gap_r),
    .out_strobe(out_strobe), .out_read_data(out_read_data),
    .out_recorded_valid(out_recorded_valid), .out_recorded_delta(out_recorded_delta),
    .out_first_toggle(out_first_toggle), .out_tape_out(out_tape_out),
    .out_tape_in(out_tape_in), .out_tape_running(out_tape_running)
  );

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("strobe held two cycles");
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("start not taken");
  a_delta_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_recorded_valid) |-> (out_recorded_delta != 32'd0))
    else $error("zero delta recorded");

endmodule
